@@ src/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, command codes and the reply byte table of the SUMP command
// decoder.
// ----------------------------------------------------------------------------
package scd_pkg;

   localparam int unsigned TOP_RATE        = 20000000;
   localparam int unsigned CAPTURE_BYTES   = 65536;
   localparam int unsigned ADVERTISED_RATE = 20000000;
   localparam int unsigned CHANNELS        = 16;

   localparam int RATE_W  = 25;
   localparam int COUNT_W = 19;
   localparam int CHAN_W  = 5;
   localparam int PTR_W   = 5;
   localparam int STEP_W  = 5;

   localparam logic [15:0] CHANNEL_MASK = 16'((33'd1 << CHANNELS) - 33'd1);
   localparam logic [RATE_W-1:0] TOP_RATE_VAL = RATE_W'(TOP_RATE);
   localparam logic [CHAN_W-1:0] NO_TRIGGER = '1;

   // short commands
   localparam logic [7:0] CMD_RESET     = 8'h00;
   localparam logic [7:0] CMD_ARM       = 8'h01;
   localparam logic [7:0] CMD_QUERY     = 8'h02;
   localparam logic [7:0] CMD_SELFTEST  = 8'h03;
   localparam logic [7:0] CMD_METADATA  = 8'h04;
   // long commands
   localparam logic [7:0] CMD_DIVIDER   = 8'h80;
   localparam logic [7:0] CMD_READ_CNT  = 8'h81;
   localparam logic [7:0] CMD_TRIG_MASK = 8'hC0;
   localparam logic [7:0] CMD_TRIG_VAL  = 8'hC1;

   // reply table layout
   localparam logic [PTR_W-1:0] ID_FIRST   = 5'd0;
   localparam logic [PTR_W-1:0] ID_LAST    = 5'd3;
   localparam logic [PTR_W-1:0] META_FIRST = 5'd4;
   localparam logic [PTR_W-1:0] META_LAST  = 5'd31;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_QUERY,
      KIND_META,
      KIND_ARM
   } kind_type;

   typedef struct packed {
      logic capture;
      logic load_query;
      logic load_meta;
      logic reply_step;
      logic div_start;
      logic show_reply;
      logic show_arm;
   } ctl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     reply_last;
      logic     div_busy;
   } ctl_stat_type;

   function automatic logic [7:0] reply_byte(input logic [PTR_W-1:0] idx);
      logic [31:0] cap;
      logic [31:0] rate;
      logic [7:0]  b;
      cap  = 32'(CAPTURE_BYTES);
      rate = 32'(ADVERTISED_RATE);
      unique case (idx)
         5'd0:    b = 8'h31;
         5'd1:    b = 8'h41;
         5'd2:    b = 8'h4C;
         5'd3:    b = 8'h53;
         5'd4:    b = 8'h01;
         5'd5:    b = 8'h45;
         5'd6:    b = 8'h53;
         5'd7:    b = 8'h50;
         5'd8:    b = 8'h33;
         5'd9:    b = 8'h32;
         5'd10:   b = 8'h00;
         5'd11:   b = 8'h02;
         5'd12:   b = 8'h30;
         5'd13:   b = 8'h2E;
         5'd14:   b = 8'h30;
         5'd15:   b = 8'h30;
         5'd16:   b = 8'h00;
         5'd17:   b = 8'h21;
         5'd18:   b = cap[31:24];
         5'd19:   b = cap[23:16];
         5'd20:   b = cap[15:8];
         5'd21:   b = cap[7:0];
         5'd22:   b = 8'h23;
         5'd23:   b = rate[31:24];
         5'd24:   b = rate[23:16];
         5'd25:   b = rate[15:8];
         5'd26:   b = rate[7:0];
         5'd27:   b = 8'h40;
         5'd28:   b = 8'(CHANNELS);
         5'd29:   b = 8'h41;
         5'd30:   b = 8'h02;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ src/scd_ctrl.sv @@
// ----------------------------------------------------------------------------
// scd_ctrl
// Sequencer: takes one host byte, then plays out reply words or runs the
// rate divider and presents the capture request.
// ----------------------------------------------------------------------------
module scd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  scd_pkg::ctl_stat_type stat,
   output scd_pkg::ctl_cmd_type  cmd
);
   import scd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_REPLY = 4'b0100,
      ST_ARM   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               unique case (stat.kind)
                  KIND_QUERY: begin
                     cmd.load_query = 1'b1;
                     state_in       = ST_REPLY;
                  end
                  KIND_META: begin
                     cmd.load_meta = 1'b1;
                     state_in      = ST_REPLY;
                  end
                  KIND_ARM: begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_DIV;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            if (!stat.div_busy) begin
               state_in = ST_ARM;
            end
         end
         ST_REPLY: begin
            rsp_valid      = 1'b1;
            cmd.show_reply = 1'b1;
            if (rsp_ready) begin
               if (stat.reply_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.reply_step = 1'b1;
               end
            end
         end
         ST_ARM: begin
            rsp_valid    = 1'b1;
            cmd.show_arm = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/scd_dpath.sv @@
// ----------------------------------------------------------------------------
// scd_dpath
// Datapath: argument collection, capture settings, reply table pointer,
// restoring rate divider and the result word fields.
// ----------------------------------------------------------------------------
module scd_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [7:0]                   req_rx_byte,
   input  scd_pkg::ctl_cmd_type         cmd,
   output scd_pkg::ctl_stat_type        stat,
   output logic                         rsp_tx_valid,
   output logic [7:0]                   rsp_tx_byte,
   output logic                         rsp_arm_valid,
   output logic [scd_pkg::COUNT_W-1:0]  rsp_sample_count,
   output logic [scd_pkg::RATE_W-1:0]   rsp_capture_rate,
   output logic signed [scd_pkg::CHAN_W-1:0] rsp_trigger_channel,
   output logic                         rsp_rising_edge,
   output logic                         rsp_last
);
   import scd_pkg::*;

   logic [2:0]         arg_left_ff, arg_left_in;
   logic [7:0]         pending_ff, pending_in;
   logic [31:0]        shift_ff, shift_in;
   logic               mask_nz_ff, mask_nz_in;
   logic [CHAN_W-1:0]  first_chan_ff, first_chan_in;
   logic               edge_ff, edge_in;
   logic [23:0]        rate_div_ff, rate_div_in;
   logic [COUNT_W-1:0] read_samples_ff, read_samples_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [PTR_W-1:0]   end_ff, end_in;
   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [RATE_W-1:0]  rem_ff, rem_in;
   logic [RATE_W-1:0]  quo_ff, quo_in;
   logic [RATE_W-1:0]  dvsr_ff, dvsr_in;

   kind_type           byte_kind;
   logic [15:0]        mask;
   logic [CHAN_W-1:0]  low_chan;
   logic [RATE_W:0]    trial;
   logic [RATE_W:0]    diff;

   // decode of the byte on the request port
   always_comb begin
      byte_kind = KIND_NONE;
      if (arg_left_ff == 3'd0 && !req_rx_byte[7]) begin
         unique case (req_rx_byte)
            CMD_QUERY:    byte_kind = KIND_QUERY;
            CMD_METADATA: byte_kind = KIND_META;
            CMD_ARM:      byte_kind = KIND_ARM;
            default:      byte_kind = KIND_NONE;
         endcase
      end
   end

   assign stat = '{kind: byte_kind, reply_last: (ptr_ff == end_ff), div_busy: busy_ff};

   // lowest set channel of the masked argument
   assign mask = shift_in[15:0] & CHANNEL_MASK;
   always_comb begin
      low_chan = NO_TRIGGER;
      for (int i = 15; i >= 0; i--) begin
         if (mask[i]) begin
            low_chan = CHAN_W'(i);
         end
      end
   end

   assign trial = {rem_ff, quo_ff[RATE_W-1]};
   assign diff  = trial - {1'b0, dvsr_ff};

   always_comb begin
      arg_left_in     = arg_left_ff;
      pending_in      = pending_ff;
      shift_in        = shift_ff;
      mask_nz_in      = mask_nz_ff;
      first_chan_in   = first_chan_ff;
      edge_in         = edge_ff;
      rate_div_in     = rate_div_ff;
      read_samples_in = read_samples_ff;
      ptr_in          = ptr_ff;
      end_in          = end_ff;
      busy_in         = busy_ff;
      step_in         = step_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      dvsr_in         = dvsr_ff;

      // collect argument bytes, run a long command on its last one
      if (cmd.capture) begin
         if (arg_left_ff != 3'd0) begin
            shift_in    = {req_rx_byte, shift_ff[31:8]};
            arg_left_in = arg_left_ff - 3'd1;
            if (arg_left_ff == 3'd1) begin
               unique case (pending_ff)
                  CMD_TRIG_MASK: begin
                     mask_nz_in    = (mask != 16'd0);
                     first_chan_in = low_chan;
                  end
                  CMD_TRIG_VAL: begin
                     edge_in = mask_nz_ff & shift_in[first_chan_ff[3:0]];
                  end
                  CMD_DIVIDER: begin
                     rate_div_in = shift_in[23:0];
                  end
                  CMD_READ_CNT: begin
                     read_samples_in = COUNT_W'({3'b000, shift_in[15:0]} + 19'd1) << 2;
                  end
                  default: pending_in = pending_ff;
               endcase
            end
         end else if (req_rx_byte[7]) begin
            pending_in  = req_rx_byte;
            arg_left_in = 3'd4;
         end
      end

      // reply pointer
      if (cmd.load_query) begin
         ptr_in = ID_FIRST;
         end_in = ID_LAST;
      end else if (cmd.load_meta) begin
         ptr_in = META_FIRST;
         end_in = META_LAST;
      end else if (cmd.reply_step) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end

      // restoring divide, one quotient bit per cycle
      if (cmd.div_start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(RATE_W - 1);
         rem_in  = '0;
         quo_in  = TOP_RATE_VAL;
         dvsr_in = {1'b0, rate_div_ff} + RATE_W'(1);
      end else if (busy_ff) begin
         if (diff[RATE_W]) begin
            rem_in = trial[RATE_W-1:0];
         end else begin
            rem_in = diff[RATE_W-1:0];
         end
         quo_in = {quo_ff[RATE_W-2:0], ~diff[RATE_W]};
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_left_ff     <= '0;
         pending_ff      <= '0;
         shift_ff        <= '0;
         mask_nz_ff      <= 1'b0;
         first_chan_ff   <= '0;
         edge_ff         <= 1'b0;
         rate_div_ff     <= '0;
         read_samples_ff <= '0;
         busy_ff         <= 1'b0;
      end else begin
         arg_left_ff     <= arg_left_in;
         pending_ff      <= pending_in;
         shift_ff        <= shift_in;
         mask_nz_ff      <= mask_nz_in;
         first_chan_ff   <= first_chan_in;
         edge_ff         <= edge_in;
         rate_div_ff     <= rate_div_in;
         read_samples_ff <= read_samples_in;
         busy_ff         <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      end_ff  <= end_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   // result word fields
   assign rsp_tx_valid        = cmd.show_reply;
   assign rsp_tx_byte         = cmd.show_reply ? reply_byte(ptr_ff) : 8'h00;
   assign rsp_arm_valid       = cmd.show_arm;
   assign rsp_sample_count    = cmd.show_arm ? read_samples_ff : '0;
   assign rsp_capture_rate    = cmd.show_arm ? quo_ff : '0;
   assign rsp_trigger_channel = cmd.show_arm ? signed'(first_chan_ff) : '0;
   assign rsp_rising_edge     = cmd.show_arm & edge_ff;
   assign rsp_last            = cmd.show_arm | (cmd.show_reply & stat.reply_last);

endmodule

@@ src/sump_command_decoder.sv @@
// ----------------------------------------------------------------------------
// sump_command_decoder
// Decodes SUMP host command bytes into reply words and capture requests.
//
//   channel   ports    handshake     payload
//   input     req_*    valid/ready   rx_byte
//   result    rsp_*    valid/ready   tx_valid tx_byte arm_valid sample_count
//                                    capture_rate trigger_channel rising_edge
//                                    last
//
// Bytes that cause no word are taken at one per cycle.
// Query gives 4 words and metadata 28, one per cycle while rsp_ready is high.
// Arm runs a restoring divider for the rate, then shows one word.
// req_ready is low from the byte's acceptance until its last word is taken.
// Reset clears all command settings; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sump_command_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_tx_valid,
   output logic [7:0]                        rsp_tx_byte,
   output logic                              rsp_arm_valid,
   output logic [scd_pkg::COUNT_W-1:0]       rsp_sample_count,
   output logic [scd_pkg::RATE_W-1:0]        rsp_capture_rate,
   output logic signed [scd_pkg::CHAN_W-1:0] rsp_trigger_channel,
   output logic                              rsp_rising_edge,
   output logic                              rsp_last
);
   import scd_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scd_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_rx_byte         (req_rx_byte),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_arm_valid       (rsp_arm_valid),
      .rsp_sample_count    (rsp_sample_count),
      .rsp_capture_rate    (rsp_capture_rate),
      .rsp_trigger_channel (rsp_trigger_channel),
      .rsp_rising_edge     (rsp_rising_edge),
      .rsp_last            (rsp_last)
   );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sump_command_decoder. Host bytes go in through the
// req_ channel in random bursts. A local decoder model predicts every reply
// and capture word. Each word taken on the rsp_ channel, under its own stall
// pattern, is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import scd_pkg::*;

   localparam logic [7:0] CMD_UNUSED_SHORT = 8'h7F;
   localparam logic [7:0] CMD_UNUSED_LONG  = 8'hA5;

   localparam logic [31:0] ID_REC = 32'h31414C53;
   localparam logic [28*8-1:0] META_REC = {
      8'h01, 8'h45, 8'h53, 8'h50, 8'h33, 8'h32, 8'h00,
      8'h02, 8'h30, 8'h2E, 8'h30, 8'h30, 8'h00,
      8'h21, 32'(CAPTURE_BYTES),
      8'h23, 32'(ADVERTISED_RATE),
      8'h40, 8'(CHANNELS), 8'h41, 8'h02, 8'h00};

   typedef struct {
      logic                     tx_valid;
      logic [7:0]               tx_byte;
      logic                     arm_valid;
      logic [COUNT_W-1:0]       sample_count;
      logic [RATE_W-1:0]        capture_rate;
      logic signed [CHAN_W-1:0] trigger_channel;
      logic                     rising_edge;
      logic                     last;
   } host_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_rx_byte = 8'h00;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_tx_valid;
   logic [7:0]               rsp_tx_byte;
   logic                     rsp_arm_valid;
   logic [COUNT_W-1:0]       rsp_sample_count;
   logic [RATE_W-1:0]        rsp_capture_rate;
   logic signed [CHAN_W-1:0] rsp_trigger_channel;
   logic                     rsp_rising_edge;
   logic                     rsp_last;

   logic [2:0]        args_left = '0;
   logic [7:0]        long_op = '0;
   logic [31:0]       arg_word = '0;
   logic              trig_enabled = 1'b0;
   logic [CHAN_W-1:0] trig_chan = '0;
   logic              trig_rising = 1'b0;
   logic [23:0]       clk_divider = '0;
   logic [COUNT_W-1:0] capture_len = '0;

   host_word_type expected_words[$];
   int         error_count = 0;
   int         burst_left = 0;
   int         stall_mode = 0;
   int         stall_cycle = 0;

   sump_command_decoder dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_arm_valid       (rsp_arm_valid),
      .rsp_sample_count    (rsp_sample_count),
      .rsp_capture_rate    (rsp_capture_rate),
      .rsp_trigger_channel (rsp_trigger_channel),
      .rsp_rising_edge     (rsp_rising_edge),
      .rsp_last            (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic host_word_type reply_word(logic [7:0] b, logic fin);
      host_word_type w;
      w = '{default: '0};
      w.tx_valid = 1'b1;
      w.tx_byte  = b;
      w.last     = fin;
      return w;
   endfunction

   function automatic void apply_long(logic [7:0] op, logic [31:0] arg);
      logic [15:0] m;
      m = arg[15:0] & CHANNEL_MASK;
      case (op)
         CMD_TRIG_MASK: begin
            trig_enabled = (m != 16'd0);
            trig_chan = NO_TRIGGER;
            for (int i = 15; i >= 0; i--)
               if (m[i]) trig_chan = CHAN_W'(i);
         end
         CMD_TRIG_VAL: trig_rising = trig_enabled ? arg[trig_chan[3:0]] : 1'b0;
         CMD_DIVIDER: clk_divider = arg[23:0];
         CMD_READ_CNT: capture_len = ({3'b000, arg[15:0]} + 19'd1) << 2;
         default: ;
      endcase
   endfunction

   function automatic void decode_host_byte(logic [7:0] b);
      host_word_type   w;
      longint unsigned rate;
      if (args_left != 3'd0) begin
         arg_word = {b, arg_word[31:8]};
         args_left = args_left - 3'd1;
         if (args_left == 3'd0) apply_long(long_op, arg_word);
      end else if (b[7]) begin
         long_op = b;
         args_left = 3'd4;
      end else begin
         case (b)
            CMD_QUERY:
               for (int i = 0; i < 4; i++)
                  expected_words.push_back(reply_word(ID_REC[(3-i)*8 +: 8], i == 3));
            CMD_METADATA:
               for (int i = 0; i < 28; i++)
                  expected_words.push_back(reply_word(META_REC[(27-i)*8 +: 8], i == 27));
            CMD_ARM: begin
               rate = 64'(TOP_RATE) / (64'(clk_divider) + 64'd1);
               if (rate > 64'h1FF_FFFF) rate = 64'h1FF_FFFF;
               w = '{default: '0};
               w.arm_valid       = 1'b1;
               w.sample_count    = capture_len;
               w.capture_rate    = RATE_W'(rate);
               w.trigger_channel = trig_chan;
               w.rising_edge     = trig_rising;
               w.last            = 1'b1;
               expected_words.push_back(w);
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void compare_field(string name, logic signed [63:0] exp_v,
                                         logic signed [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   task automatic send_byte(logic [7:0] b);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      decode_host_byte(b);
   endtask

   task automatic send_long(logic [7:0] op, logic [31:0] arg);
      send_byte(op);
      for (int i = 0; i < 4; i++)
         send_byte(arg[i*8 +: 8]);
   endtask

   task automatic test_short_commands();
      send_byte(CMD_ARM);
      send_byte(CMD_QUERY);
      send_byte(CMD_METADATA);
      send_byte(CMD_RESET);
      send_byte(CMD_SELFTEST);
      send_byte(CMD_UNUSED_SHORT);
   endtask

   task automatic test_trigger_disabled();
      send_long(CMD_TRIG_MASK, 32'hFFFF_0000);
      send_long(CMD_TRIG_VAL, 32'hFFFF_FFFF);
      send_byte(CMD_ARM);
   endtask

   task automatic test_argument_limits();
      send_long(CMD_DIVIDER, 32'h04FF_FFFF);
      send_long(CMD_READ_CNT, 32'h8102_FFFF);
      send_byte(CMD_ARM);
   endtask

   task automatic test_unknown_long();
      send_long(CMD_UNUSED_LONG, 32'h0201_C0FF);
   endtask

   task automatic test_random_traffic();
      int          decoded;
      int          pick;
      logic [7:0]  op;
      logic [31:0] arg;
      decoded = 0;
      while (decoded < 328) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            arg = $urandom;
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  op = CMD_TRIG_MASK;
                  case ($urandom_range(0, 3))
                     0: arg = '0;
                     1: arg = 32'd1 << $urandom_range(0, 31);
                     2: arg = $urandom;
                     default: arg = $urandom << $urandom_range(0, 16);
                  endcase
               end
               3, 4: op = CMD_TRIG_VAL;
               5, 6: begin
                  op = CMD_DIVIDER;
                  case ($urandom_range(0, 2))
                     0: arg = $urandom_range(0, 15);
                     1: arg = $urandom & 32'hFF;
                     default: arg = $urandom;
                  endcase
               end
               7, 8: op = CMD_READ_CNT;
               default: op = 8'($urandom_range(128, 255));
            endcase
            send_long(op, arg);
            decoded += 5;
         end else if (pick < 60) begin
            send_byte(CMD_ARM);
            decoded++;
         end else if (pick < 72) begin
            send_byte(CMD_QUERY);
            decoded++;
         end else if (pick < 78) begin
            send_byte(CMD_METADATA);
            decoded++;
         end else if (pick < 90) begin
            send_byte(8'($urandom_range(0, 127)));
            decoded++;
         end else begin
            send_byte(8'($urandom));
            decoded++;
         end
      end
   endtask

   // stall the result side in changing patterns
   always @(negedge clock) begin
      if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
      stall_cycle++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ((stall_cycle % 9) < 4);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   always @(posedge clock) begin
      host_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: tx_byte %0h arm_valid %0b", rsp_tx_byte, rsp_arm_valid);
            error_count++;
         end else begin
            w = expected_words.pop_front();
            compare_field("tx_valid", w.tx_valid, rsp_tx_valid);
            compare_field("tx_byte", w.tx_byte, rsp_tx_byte);
            compare_field("arm_valid", w.arm_valid, rsp_arm_valid);
            compare_field("sample_count", w.sample_count, rsp_sample_count);
            compare_field("capture_rate", w.capture_rate, rsp_capture_rate);
            compare_field("trigger_channel", w.trigger_channel, rsp_trigger_channel);
            compare_field("rising_edge", w.rising_edge, rsp_rising_edge);
            compare_field("last", w.last, rsp_last);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_short_commands();
      test_trigger_disabled();
      test_argument_limits();
      test_unknown_long();
      test_random_traffic();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (error_count == 0)
         $display("** sump_command_decoder: PASSED **");
      else
         $display("** sump_command_decoder: FAILED **");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("** sump_command_decoder: FAILED **");
      $finish;
   end

endmodule
